// ===== rtl/cst_pkg.sv =====
// Shared types and codes for the client slot table.
// Used by cst_match and client_slot_table_with_timeout; depends on nothing.
package cst_pkg;

   localparam int CMD_W   = 3;
   localparam int ID_W    = 8;
   localparam int MODE_W  = 2;
   localparam int ADDR_W  = 48;
   localparam int TIME_W  = 32;
   localparam int KIND_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam int SLOT_REACH = 16;

   localparam logic [CMD_W-1:0] CMD_CONNECT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SYNC       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DISCONNECT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DATA       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWEEP      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FANOUT     = 3'd5;

   localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALL     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALL_BUT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BAD     = 2'd3;

   localparam logic [KIND_W-1:0] KIND_GRANTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TARGET  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_KICKED  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SLOTS    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECEIVE_TIMEOUT = 8'd1;

   localparam logic [COUNT_W-1:0] ACTIVE_SLOTS_RESET    = 5'd16;
   localparam logic [TIME_W-1:0]  RECEIVE_TIMEOUT_RESET = 32'd1000;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [MODE_W-1:0] dest_mode;
      logic              slot_is_id;
      logic              connected;
   } match_ctl_type;

endpackage

// ===== rtl/cst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cst_match.sv =====
// Shared slot test: free-slot check, wrap-around age compare, fan-out target test.
// Depends on cst_pkg.
module cst_match (
   input  cst_pkg::match_ctl_type      ctl,
   input  logic [cst_pkg::TIME_W-1:0]  now_ms,
   input  logic [cst_pkg::TIME_W-1:0]  last_heard,
   input  logic [cst_pkg::TIME_W-1:0]  receive_timeout,
   output logic                        hit
);

   logic [cst_pkg::TIME_W-1:0] age;
   logic                       expired;
   logic                       targeted;

   assign age     = now_ms - last_heard;
   assign expired = age >= receive_timeout;

   always_comb begin
      unique case (ctl.dest_mode)
         cst_pkg::MODE_SINGLE:  targeted = ctl.slot_is_id;
         cst_pkg::MODE_ALL:     targeted = 1'b1;
         cst_pkg::MODE_ALL_BUT: targeted = !ctl.slot_is_id;
         default:               targeted = 1'b0;
      endcase
   end

   always_comb begin
      unique case (ctl.command)
         cst_pkg::CMD_CONNECT: hit = !ctl.connected;
         cst_pkg::CMD_SWEEP:   hit = ctl.connected && expired;
         cst_pkg::CMD_FANOUT:  hit = ctl.connected && targeted;
         default:              hit = 1'b0;
      endcase
   end

endmodule

// ===== rtl/client_slot_table_with_timeout.sv =====
// Client slot table with receive timeout: sequencer, connected flags, slot stores.
// Depends on cst_pkg, cst_ram and cst_match.
//
// Usage:
//  - req_* carries one command item; it is taken when req_valid is high and
//    req_stall is low. req_stall is high from the cycle after an item is taken
//    until its last result has been loaded into the output register.
//  - rsp_* returns result items; rsp_last marks the final one of a command.
//    Every command gives at least one result.
//  - csr_* writes active_slots (index 0) and receive_timeout (index 1); it is
//    always ready. Write only while the block is idle.
//  - Sync, data and disconnect pass through ST_ONE to ST_FINAL, which loads
//    their result. An out-of-range id, a bad fan-out mode or a reserved
//    command goes straight from ST_IDLE to ST_FINAL.
//  - Connect, sweep and fan-out scan the first n slots, n = min(active_slots,
//    MAX_SLOTS, 16), one per cycle through the shared slot test unless paused
//    as below; the last result is loaded from ST_FINAL. Connect stops at the
//    first free slot. A scanned result is held one step so that rsp_last can
//    be set on the final one.
//  - When rsp_stall holds a result, the scan pauses on its next hit until the
//    output register frees; nothing is dropped.
//  - Reset (synchronous) clears all slots to free and restores the register
//    defaults of 16 slots and a 1000 ms timeout.
module client_slot_table_with_timeout #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cst_pkg::CMD_W-1:0]       req_command,
   input  logic [cst_pkg::ID_W-1:0]        req_client_id,
   input  logic [cst_pkg::MODE_W-1:0]      req_dest_mode,
   input  logic [cst_pkg::ADDR_W-1:0]      req_peer_address,
   input  logic [cst_pkg::TIME_W-1:0]      req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cst_pkg::KIND_W-1:0]      rsp_kind,
   output logic [cst_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [cst_pkg::ADDR_W-1:0]      rsp_target_address,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cst_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int DEPTH = (MAX_SLOTS < cst_pkg::SLOT_REACH) ? MAX_SLOTS : cst_pkg::SLOT_REACH;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ONE,
      ST_SCAN,
      ST_FINAL
   } state_type;

   state_type                      state_ff;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic                           conn_ff [DEPTH];
   logic [cst_pkg::COUNT_W-1:0]    active_ff;
   logic [cst_pkg::TIME_W-1:0]     timeout_ff;

   logic [cst_pkg::CMD_W-1:0]      cmd_ff;
   logic [cst_pkg::ID_W-1:0]       id_ff;
   logic [cst_pkg::MODE_W-1:0]     mode_ff;
   logic [cst_pkg::ADDR_W-1:0]     peer_ff;
   logic [cst_pkg::TIME_W-1:0]     now_ff;

   logic                           pend_valid_ff;
   logic [cst_pkg::KIND_W-1:0]     pend_kind_ff;
   logic [cst_pkg::SLOT_W-1:0]     pend_slot_ff;
   logic [cst_pkg::ADDR_W-1:0]     pend_addr_ff;

   logic                           rsp_valid_ff;
   logic [cst_pkg::KIND_W-1:0]     rsp_kind_ff;
   logic [cst_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [cst_pkg::ADDR_W-1:0]     rsp_addr_ff;
   logic                           rsp_last_ff;

   logic [cst_pkg::COUNT_W-1:0]    n_eff;
   logic                           out_free;
   logic                           req_single;
   logic                           req_id_ok;
   logic                           conn_cur;
   logic                           last_idx;
   logic                           hit;
   logic                           scan_hold;
   logic                           rsp_load;
   logic                           time_we;
   logic                           addr_we;
   logic [cst_pkg::ADDR_W-1:0]     rd_addr_data;
   logic [cst_pkg::TIME_W-1:0]     rd_time_data;
   cst_pkg::match_ctl_type         match_ctl;

   assign n_eff = (active_ff > cst_pkg::COUNT_W'(DEPTH)) ? cst_pkg::COUNT_W'(DEPTH) : active_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_single = (req_command == cst_pkg::CMD_SYNC) ||
                       (req_command == cst_pkg::CMD_DISCONNECT) ||
                       (req_command == cst_pkg::CMD_DATA);
   assign req_id_ok  = req_client_id < cst_pkg::ID_W'(n_eff);
   assign conn_cur   = conn_ff[idx_ff];
   assign last_idx   = (cst_pkg::COUNT_W'(idx_ff) + cst_pkg::COUNT_W'(1)) == n_eff;

   assign match_ctl.command    = cmd_ff;
   assign match_ctl.dest_mode  = mode_ff;
   assign match_ctl.slot_is_id = cst_pkg::ID_W'(idx_ff) == id_ff;
   assign match_ctl.connected  = conn_cur;

   cst_match u_match (
      .ctl             (match_ctl),
      .now_ms          (now_ff),
      .last_heard      (rd_time_data),
      .receive_timeout (timeout_ff),
      .hit             (hit)
   );

   assign scan_hold = (state_ff == ST_SCAN) && (cmd_ff != cst_pkg::CMD_CONNECT) &&
                      hit && pend_valid_ff && !out_free;
   assign rsp_load  = ((state_ff == ST_SCAN) && (cmd_ff != cst_pkg::CMD_CONNECT) &&
                       !scan_hold && hit && pend_valid_ff) ||
                      ((state_ff == ST_FINAL) && out_free);

   always_comb begin
      idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = (req_valid && req_single) ? req_client_id[IDX_W-1:0] : '0;
         end
         ST_SCAN: begin
            if (!scan_hold && !last_idx &&
                !((cmd_ff == cst_pkg::CMD_CONNECT) && hit)) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: idx_in = idx_ff;
      endcase
   end

   assign addr_we = (state_ff == ST_SCAN) && (cmd_ff == cst_pkg::CMD_CONNECT) && hit;
   assign time_we = addr_we ||
                    ((state_ff == ST_ONE) && conn_cur &&
                     ((cmd_ff == cst_pkg::CMD_SYNC) || (cmd_ff == cst_pkg::CMD_DATA)));

   cst_ram #(.WIDTH(cst_pkg::ADDR_W), .DEPTH(DEPTH)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_we),
      .wr_addr (idx_ff),
      .wr_data (peer_ff),
      .rd_addr (idx_in),
      .rd_data (rd_addr_data)
   );

   cst_ram #(.WIDTH(cst_pkg::TIME_W), .DEPTH(DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (idx_ff),
      .wr_data (now_ff),
      .rd_addr (idx_in),
      .rd_data (rd_time_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         active_ff     <= cst_pkg::ACTIVE_SLOTS_RESET;
         timeout_ff    <= cst_pkg::RECEIVE_TIMEOUT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            conn_ff[i] <= 1'b0;
         end
      end else begin
         idx_ff <= idx_in;
         if (csr_valid) begin
            if (csr_index == cst_pkg::CSR_ACTIVE_SLOTS) begin
               active_ff <= csr_data[cst_pkg::COUNT_W-1:0];
            end else if (csr_index == cst_pkg::CSR_RECEIVE_TIMEOUT) begin
               timeout_ff <= csr_data[cst_pkg::TIME_W-1:0];
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff        <= req_command;
                  id_ff         <= req_client_id;
                  mode_ff       <= req_dest_mode;
                  peer_ff       <= req_peer_address;
                  now_ff        <= req_now_ms;
                  pend_kind_ff  <= ((req_command == cst_pkg::CMD_CONNECT) && (n_eff == '0)) ?
                                   cst_pkg::KIND_REFUSED : cst_pkg::KIND_IGNORED;
                  pend_slot_ff  <= '0;
                  pend_addr_ff  <= '0;
                  priority if (req_single) begin
                     pend_valid_ff <= !req_id_ok;
                     state_ff      <= req_id_ok ? ST_ONE : ST_FINAL;
                  end else if (req_command == cst_pkg::CMD_CONNECT) begin
                     pend_valid_ff <= (n_eff == '0);
                     state_ff      <= (n_eff == '0) ? ST_FINAL : ST_SCAN;
                  end else if (req_command == cst_pkg::CMD_SWEEP) begin
                     pend_valid_ff <= 1'b0;
                     state_ff      <= (n_eff == '0) ? ST_FINAL : ST_SCAN;
                  end else if (req_command == cst_pkg::CMD_FANOUT) begin
                     if ((req_dest_mode == cst_pkg::MODE_BAD) ||
                         ((req_dest_mode != cst_pkg::MODE_ALL) && !req_id_ok)) begin
                        pend_valid_ff <= 1'b1;
                        state_ff      <= ST_FINAL;
                     end else begin
                        pend_valid_ff <= 1'b0;
                        state_ff      <= (n_eff == '0) ? ST_FINAL : ST_SCAN;
                     end
                  end else begin
                     pend_valid_ff <= 1'b1;
                     state_ff      <= ST_FINAL;
                  end
               end
            end
            ST_ONE: begin
               pend_valid_ff <= 1'b1;
               if (conn_cur) begin
                  pend_kind_ff <= cst_pkg::KIND_DONE;
                  if (cmd_ff == cst_pkg::CMD_DISCONNECT) begin
                     conn_ff[idx_ff] <= 1'b0;
                  end
               end else begin
                  pend_kind_ff <= cst_pkg::KIND_IGNORED;
               end
               state_ff <= ST_FINAL;
            end
            ST_SCAN: begin
               if (cmd_ff == cst_pkg::CMD_CONNECT) begin
                  if (hit) begin
                     conn_ff[idx_ff] <= 1'b1;
                     pend_valid_ff   <= 1'b1;
                     pend_kind_ff    <= cst_pkg::KIND_GRANTED;
                     pend_slot_ff    <= cst_pkg::SLOT_W'(idx_ff);
                     pend_addr_ff    <= peer_ff;
                     state_ff        <= ST_FINAL;
                  end else if (last_idx) begin
                     pend_valid_ff <= 1'b1;
                     pend_kind_ff  <= cst_pkg::KIND_REFUSED;
                     state_ff      <= ST_FINAL;
                  end
               end else if (!scan_hold) begin
                  if (hit) begin
                     if (pend_valid_ff) begin
                        rsp_kind_ff  <= pend_kind_ff;
                        rsp_slot_ff  <= pend_slot_ff;
                        rsp_addr_ff  <= pend_addr_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_kind_ff  <= (cmd_ff == cst_pkg::CMD_SWEEP) ?
                                      cst_pkg::KIND_KICKED : cst_pkg::KIND_TARGET;
                     pend_slot_ff  <= cst_pkg::SLOT_W'(idx_ff);
                     pend_addr_ff  <= rd_addr_data;
                     if (cmd_ff == cst_pkg::CMD_SWEEP) begin
                        conn_ff[idx_ff] <= 1'b0;
                     end
                  end
                  if (last_idx) begin
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_FINAL: begin
               if (out_free) begin
                  rsp_kind_ff   <= pend_valid_ff ? pend_kind_ff : cst_pkg::KIND_NONE;
                  rsp_slot_ff   <= pend_valid_ff ? pend_slot_ff : '0;
                  rsp_addr_ff   <= pend_valid_ff ? pend_addr_ff : '0;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall          = state_ff != ST_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_target_address = rsp_addr_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
